@@ design/mcbd_pkg.sv @@
package mcbd_pkg;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [1:0] {
        RC_DONE  = 2'd0,
        RC_FULL  = 2'd1,
        RC_EMPTY = 2'd2
    } t_rcode;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  queue_index;
        logic [15:0] entry_id;
        logic        urgent;
    } t_item;

    typedef struct packed {
        t_rcode      result_code;
        logic [15:0] out_id;
        logic        out_urgent;
        logic [3:0]  length_after;
    } t_result;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic        opcode;
        logic        class_ok;
        logic [3:0]  queue_index;
        logic [15:0] entry_id;
        logic        urgent;
    } t_cmd;

    typedef enum logic {
        ST_ISSUE,
        ST_READ
    } t_state;

endpackage

@@ design/multi_class_bounded_deque_core.sv @@
// Channel   Direction  Handshake     Word
// input     in         push / full   i_item   (opcode, class, id, urgent)
// result    out        empty / pop   o_result (code, id, urgent, length after)
//
// An enqueue, a refused enqueue, an empty dequeue or an unknown class is answered
// in the issue state of the back part; a dequeue that returns an entry goes on to
// the read state for the registered read of the entry store. A word is registered
// in the two-word command queue, and full is high while that queue holds two words.
// Synchronous active-low reset clears the head and length tables and both queues,
// not the entry store; the back part waits while the result queue is full.
module multi_class_bounded_deque_core #(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  mcbd_pkg::t_item   i_item,
    output logic              empty,
    input  logic              pop,
    output mcbd_pkg::t_result o_result
);

    import mcbd_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    mcbd_front #(
        .NUM_QUEUES (NUM_QUEUES),
        .ID_WIDTH   (ID_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    mcbd_back #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

@@ design/mcbd_fifo.sv @@
module mcbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CW'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ design/mcbd_front.sv @@
module mcbd_front #(
    parameter int NUM_QUEUES = 16,
    parameter int ID_WIDTH   = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mcbd_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_cmd_valid,
    input  logic            i_cmd_pop,
    output mcbd_pkg::t_cmd  o_cmd
);

    import mcbd_pkg::*;

    localparam int SW = (ID_WIDTH < 16) ? ID_WIDTH : 16;
    localparam logic [15:0] IdMask = 16'((32'd1 << SW) - 32'd1);

    t_cmd cmd_in;
    logic cmd_empty;

    // A class beyond the configured count answers full to an enqueue and empty to a dequeue.
    always_comb begin
        cmd_in.opcode      = i_item.opcode;
        cmd_in.class_ok    = (32'(i_item.queue_index) < NUM_QUEUES);
        cmd_in.queue_index = i_item.queue_index;
        cmd_in.entry_id    = i_item.entry_id & IdMask;
        cmd_in.urgent      = i_item.urgent;
    end

    mcbd_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (cmd_empty)
    );

    assign o_cmd_valid = !cmd_empty;

endmodule

@@ design/mcbd_back.sv @@
module mcbd_back #(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  mcbd_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output mcbd_pkg::t_result o_result
);

    import mcbd_pkg::*;

    localparam int SW    = (ID_WIDTH < 16) ? ID_WIDTH : 16;
    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Per-class head and length tables, cleared by reset.
    logic [HW-1:0] r_head [NUM_QUEUES];
    logic [LW-1:0] r_len  [NUM_QUEUES];

    // Entry store: urgent flag above the id.
    logic [SW:0]   r_ram [SLOTS];
    logic [SW:0]   r_rd_word;
    logic [LW-1:0] r_pend_len;
    logic [LW-1:0] n_pend_len;

    t_state        r_state;
    t_state        n_state;

    logic [QW-1:0] q;
    logic [HW-1:0] head;
    logic [LW-1:0] len;
    logic [HW-1:0] head_dec;
    logic [HW-1:0] head_inc;
    logic [LW:0]   tail_sum;
    logic [HW-1:0] ofs;
    logic [AW-1:0] slot;
    logic          tbl_we;
    logic [HW-1:0] n_head;
    logic [LW-1:0] n_len;
    logic          wr_en;
    logic          rd_en;
    logic          res_push;
    logic          res_full;
    t_result       res_word;

    assign q        = QW'(i_cmd.queue_index);
    assign head     = r_head[q];
    assign len      = r_len[q];
    assign head_dec = (head == '0) ? HW'(QUEUE_DEPTH - 1) : head - HW'(1);
    assign head_inc = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + HW'(1);
    // Head is below the depth and length at most the depth, so one subtract wraps the sum.
    assign tail_sum = (LW + 1)'(head) + (LW + 1)'(len);

    always_comb begin
        n_state    = r_state;
        n_pend_len = r_pend_len;
        o_cmd_pop  = 1'b0;
        tbl_we     = 1'b0;
        n_head     = head;
        n_len      = len;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        res_push   = 1'b0;
        ofs        = head;
        res_word   = '{result_code: RC_DONE, out_id: '0, out_urgent: 1'b0,
                       length_after: '0};

        if (i_cmd.opcode == OP_ENQUEUE) begin
            if (i_cmd.urgent) begin
                ofs = head_dec;
            end else if (tail_sum >= (LW + 1)'(QUEUE_DEPTH)) begin
                ofs = HW'(tail_sum - (LW + 1)'(QUEUE_DEPTH));
            end else begin
                ofs = HW'(tail_sum);
            end
        end
        slot = AW'(32'(q) * QUEUE_DEPTH + 32'(ofs));

        unique case (r_state)
            ST_ISSUE: begin
                if (i_cmd_valid && !res_full) begin
                    o_cmd_pop = 1'b1;
                    if (!i_cmd.class_ok) begin
                        res_push = 1'b1;
                        res_word.result_code =
                            (i_cmd.opcode == OP_DEQUEUE) ? RC_EMPTY : RC_FULL;
                    end else if (i_cmd.opcode == OP_ENQUEUE) begin
                        res_push = 1'b1;
                        if (len >= LW'(QUEUE_DEPTH)) begin
                            res_word.result_code  = RC_FULL;
                            res_word.length_after = 4'(len);
                        end else begin
                            wr_en  = 1'b1;
                            tbl_we = 1'b1;
                            n_len  = len + LW'(1);
                            if (i_cmd.urgent) begin
                                n_head = head_dec;
                            end
                            res_word.length_after = 4'(len + LW'(1));
                        end
                    end else if (len == '0) begin
                        res_push = 1'b1;
                        res_word.result_code = RC_EMPTY;
                    end else begin
                        rd_en      = 1'b1;
                        tbl_we     = 1'b1;
                        n_head     = head_inc;
                        n_len      = len - LW'(1);
                        n_pend_len = len - LW'(1);
                        n_state    = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // The result queue had room at issue and has only drained since.
                res_push              = 1'b1;
                res_word.out_id       = 16'(r_rd_word[SW-1:0]);
                res_word.out_urgent   = r_rd_word[SW];
                res_word.length_after = 4'(r_pend_len);
                n_state               = ST_ISSUE;
            end
            default: begin
                n_state = ST_ISSUE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ISSUE;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_len[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (tbl_we) begin
                r_head[q] <= n_head;
                r_len[q]  <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_len <= n_pend_len;
        if (wr_en) begin
            r_ram[slot] <= {i_cmd.urgent, i_cmd.entry_id[SW-1:0]};
        end
        if (rd_en) begin
            r_rd_word <= r_ram[slot];
        end
    end

    mcbd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_word),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule
